@@ design/chs_pkg.sv @@
// ----------------------------------------------------------------------------
// chs_pkg
// Shared types and constants of the character sorter.
// ----------------------------------------------------------------------------
package chs_pkg;

    // Capacity of the insertion chain, one character per cell.
    localparam int MAX_LEN = 32;

    typedef enum logic
    {
        ST_LOAD,
        ST_DRAIN
    } chs_state_t;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed
    {
        logic load;   // insert the broadcast character
        logic shift;  // move every entry one cell toward the head
    } chs_ctrl_t;

endpackage

@@ design/chs_cell.sv @@
// ----------------------------------------------------------------------------
// chs_cell
// One cell of the sorting chain: holds one character and a valid bit.
// ----------------------------------------------------------------------------
module chs_cell
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  chs_pkg::chs_ctrl_t   ctrl,
    input  logic signed [7:0]    char_in,
    input  logic signed [7:0]    left_value,
    input  logic                 left_valid,
    input  logic                 left_gt,
    input  logic signed [7:0]    right_value,
    input  logic                 right_valid,
    output logic signed [7:0]    value,
    output logic                 valid,
    output logic                 gt
);

    logic signed [7:0] value_reg;
    logic signed [7:0] value_next;
    logic              valid_reg;
    logic              valid_next;

    // An empty cell acts as plus infinity, so the greater flags form a
    // suffix of the chain and the new character lands at the first one.
    assign gt = !valid_reg || (value_reg > char_in);

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctrl.shift)
        begin
            value_next = right_value;
            valid_next = right_valid;
        end
        else if (ctrl.load && gt)
        begin
            value_next = left_gt ? left_value : char_in;
            valid_next = valid_reg | left_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign valid = valid_reg;

endmodule

@@ design/character_sorter.sv @@
// ----------------------------------------------------------------------------
// character_sorter
// Sorts a string of signed 8-bit characters in a systolic insertion chain.
// ----------------------------------------------------------------------------
// Each accepted character is inserted in place into a chain of MAX_LEN cells,
// so characters load at one per cycle and the string is already sorted when
// its last character arrives. After the transaction that carries
// end_of_string the chain drains from its head, one result per cycle while
// out_stall is low, ascending in signed order, and in_stall stays high during
// the drain. Characters beyond MAX_LEN are dropped and reported by overflow
// on the result that carries last_out.
module character_sorter
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic signed [7:0] char_in,
    input  logic              end_of_string,
    output logic              out_valid,
    input  logic              out_stall,
    output logic signed [7:0] sorted_char,
    output logic              last_out,
    output logic              overflow
);

    localparam int N = chs_pkg::MAX_LEN;

    chs_pkg::chs_state_t state_reg;
    chs_pkg::chs_state_t state_next;
    logic                dropped_reg;
    logic                dropped_next;
    chs_pkg::chs_ctrl_t  ctrl;
    logic                in_take;
    logic                out_take;
    logic                full;

    logic signed [7:0]   cell_value [N];
    logic                cell_valid [N];
    logic                cell_gt    [N];

    assign full     = cell_valid[N-1];
    assign in_take  = in_valid && !in_stall;
    assign out_take = out_valid && !out_stall;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            chs_pkg::ST_LOAD:
            begin
                if (in_take && end_of_string)
                begin
                    state_next = chs_pkg::ST_DRAIN;
                end
            end
            chs_pkg::ST_DRAIN:
            begin
                if (out_take && last_out)
                begin
                    state_next = chs_pkg::ST_LOAD;
                end
            end
            default:
            begin
                state_next = chs_pkg::ST_LOAD;
            end
        endcase
    end

    // Outputs of the controller
    always_comb
    begin
        in_stall   = 1'b1;
        out_valid  = 1'b0;
        ctrl.load  = 1'b0;
        ctrl.shift = 1'b0;
        unique case (state_reg)
            chs_pkg::ST_LOAD:
            begin
                in_stall  = 1'b0;
                ctrl.load = in_take && !full;
            end
            chs_pkg::ST_DRAIN:
            begin
                out_valid  = 1'b1;
                ctrl.shift = out_take;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        dropped_next = dropped_reg;
        if (in_take && full)
        begin
            dropped_next = 1'b1;
        end
        else if (out_take && last_out)
        begin
            dropped_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= chs_pkg::ST_LOAD;
            dropped_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            dropped_reg <= dropped_next;
        end
    end

    genvar i;
    generate
        for (i = 0; i < N; i++)
        begin : g_cell
            logic signed [7:0] lv;
            logic              lval;
            logic              lgt;
            logic signed [7:0] rv;
            logic              rval;

            if (i == 0)
            begin : g_head
                assign lv   = char_in;
                assign lval = 1'b1;
                assign lgt  = 1'b0;
            end
            else
            begin : g_body
                assign lv   = cell_value[i-1];
                assign lval = cell_valid[i-1];
                assign lgt  = cell_gt[i-1];
            end

            if (i == N - 1)
            begin : g_tail
                assign rv   = cell_value[i];
                assign rval = 1'b0;
            end
            else
            begin : g_mid
                assign rv   = cell_value[i+1];
                assign rval = cell_valid[i+1];
            end

            chs_cell u_cell
            (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .char_in     (char_in),
                .left_value  (lv),
                .left_valid  (lval),
                .left_gt     (lgt),
                .right_value (rv),
                .right_valid (rval),
                .value       (cell_value[i]),
                .valid       (cell_valid[i]),
                .gt          (cell_gt[i])
            );
        end
    endgenerate

    // The head cell is the output register; the final result is the one
    // with nothing behind it.
    assign sorted_char = cell_value[0];
    assign last_out    = !cell_valid[1];
    assign overflow    = last_out && dropped_reg;

endmodule

@@ design/chs_checker.sv @@
// ----------------------------------------------------------------------------
// chs_checker
// Port-level checks of the character sorter, bound to the top level.
// ----------------------------------------------------------------------------
module chs_checker
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              end_of_string,
    input logic              out_valid,
    input logic              out_stall,
    input logic signed [7:0] sorted_char,
    input logic              last_out,
    input logic              overflow
);

    // No input transaction while results are pending.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while draining");

    // The final character starts the output burst.
    a_burst_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && end_of_string) |=> out_valid)
        else $error("no result after end of string");

    // The burst runs without gaps until last_out.
    a_burst_cont: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last_out) |=> out_valid)
        else $error("burst ended before last_out");

    // Results come out in ascending signed order.
    a_ascending: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last_out) |=>
            (sorted_char >= $past(sorted_char)))
        else $error("results out of order");

    a_overflow_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && overflow) |-> last_out)
        else $error("overflow on a non-final result");

endmodule

bind character_sorter chs_checker u_chs_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .end_of_string (end_of_string),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .sorted_char   (sorted_char),
    .last_out      (last_out),
    .overflow      (overflow)
);
